@@ hdl/double_ended_queue_unit_assert.svh @@
// Assertion macros for the double-ended queue unit
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deq assertion failed");
// next-cycle implication
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deq assertion failed");
`else
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/deq_pkg.sv @@
// Types, codes and constants shared by the double-ended queue unit
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEQ_DEPTH  = 16;
    localparam int DEQ_QDEPTH = 2;

    typedef logic        [2:0]  t_kind;
    typedef logic signed [31:0] t_word;
    typedef logic        [1:0]  t_status;
    typedef logic        [4:0]  t_count;

    localparam t_kind KIND_PUSH_BACK  = 3'd0;
    localparam t_kind KIND_PUSH_FRONT = 3'd1;
    localparam t_kind KIND_POP_BACK   = 3'd2;
    localparam t_kind KIND_POP_FRONT  = 3'd3;
    localparam t_kind KIND_TRAVERSE   = 3'd4;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_POP_BACK,
        OP_POP_FRONT,
        OP_TRAVERSE,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op   op;
        t_word value;
    } t_cmd;

    typedef struct packed {
        t_word   value_out;
        t_status status;
        t_count  entry_count;
        logic    last_of_run;
    } t_rsp;

    function automatic t_rsp f_rsp(input t_word value, input t_status status,
                                   input t_count count, input logic last);
        t_rsp r;
        r.value_out   = value;
        r.status      = status;
        r.entry_count = count;
        r.last_of_run = last;
        return r;
    endfunction

endpackage

@@ hdl/deq_if.sv @@
// Request and response channel interfaces of the double-ended queue unit
`timescale 1ns / 1ps

interface deq_req_if import deq_pkg::*; ();
    logic  valid;
    logic  ready;
    t_kind kind;
    t_word push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
    logic    valid;
    logic    ready;
    t_word   value_out;
    t_status status;
    t_count  entry_count;
    logic    last_of_run;

    modport source (output valid, output value_out, output status, output entry_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input value_out, input status, input entry_count,
                    input last_of_run, output ready);
endinterface

@@ hdl/deq_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/deq_front.sv @@
// Request intake: decode each word and hold it in a short command queue
`timescale 1ns / 1ps

module deq_front import deq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_req_if.sink    i_req,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);

    localparam int QA_W = $clog2(DEQ_QDEPTH);
    localparam int QF_W = $clog2(DEQ_QDEPTH + 1);

    t_cmd            r_q [DEQ_QDEPTH];
    logic [QA_W-1:0] r_wr, r_rd;
    logic [QF_W-1:0] r_fill, n_fill;
    logic            push, pop;
    t_cmd            cmd_in;

    function automatic t_op f_classify(input t_kind kind);
        case (kind)
            KIND_PUSH_BACK:  return OP_PUSH_BACK;
            KIND_PUSH_FRONT: return OP_PUSH_FRONT;
            KIND_POP_BACK:   return OP_POP_BACK;
            KIND_POP_FRONT:  return OP_POP_FRONT;
            KIND_TRAVERSE:   return OP_TRAVERSE;
            default:         return OP_NOP;
        endcase
    endfunction

    function automatic logic [QA_W-1:0] f_next(input logic [QA_W-1:0] p);
        if (p == QA_W'(DEQ_QDEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign i_req.ready  = (r_fill != QF_W'(DEQ_QDEPTH));
    assign o_cmd_valid  = (r_fill != '0);
    assign o_cmd        = r_q[r_rd];
    assign push         = i_req.valid && i_req.ready;
    assign pop          = o_cmd_valid && i_cmd_ready;
    assign cmd_in.op    = f_classify(i_req.kind);
    assign cmd_in.value = i_req.push_value;

    always_comb begin
        n_fill = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
            if (push) begin
                r_wr <= f_next(r_wr);
            end
            if (pop) begin
                r_rd <= f_next(r_rd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
    end

endmodule

@@ hdl/deq_back.sv @@
// Command execution: ring pointers, entry store and the result register
`timescale 1ns / 1ps

module deq_back import deq_pkg::*; #(
    parameter int DEPTH = DEQ_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    deq_rsp_if.source  o_rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_TRAV = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [31:0]      rd_data;
    logic             out_free, is_full, is_empty, trav_last;

    function automatic logic [IDX_W-1:0] f_wrap(input logic [IDX_W-1:0] pos,
                                                input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(pos) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    deq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign o_cmd_ready = (r_state == ST_IDLE) && out_free;
    assign is_full     = (r_count == CNT_W'(DEPTH));
    assign is_empty    = (r_count == '0);
    assign trav_last   = ((CNT_W'(r_idx) + 1'b1) == r_count);

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_front;
        rd_en       = 1'b0;
        rd_addr     = r_front;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    n_out_valid = 1'b1;
                    case (i_cmd.op)
                        OP_PUSH_BACK, OP_PUSH_FRONT: begin
                            if (is_full) begin
                                n_out = f_rsp('0, STATUS_FULL, t_count'(r_count), 1'b1);
                            end else begin
                                wr_en = 1'b1;
                                if (i_cmd.op == OP_PUSH_BACK) begin
                                    wr_addr = f_wrap(r_front, r_count);
                                end else begin
                                    n_front = f_wrap(r_front, CNT_W'(DEPTH - 1));
                                    wr_addr = n_front;
                                end
                                n_count = r_count + 1'b1;
                                n_out   = f_rsp('0, STATUS_OK, t_count'(n_count), 1'b1);
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT: begin
                            if (is_empty) begin
                                n_out = f_rsp('0, STATUS_EMPTY, t_count'(r_count), 1'b1);
                            end else begin
                                n_out_valid = 1'b0;
                                rd_en       = 1'b1;
                                if (i_cmd.op == OP_POP_BACK) begin
                                    rd_addr = f_wrap(r_front, r_count - 1'b1);
                                end else begin
                                    n_front = f_wrap(r_front, CNT_W'(1));
                                end
                                n_count = r_count - 1'b1;
                                n_state = ST_POP;
                            end
                        end
                        OP_TRAVERSE: begin
                            if (is_empty) begin
                                n_out = f_rsp('0, STATUS_EMPTY, t_count'(r_count), 1'b1);
                            end else begin
                                n_out_valid = 1'b0;
                                rd_en       = 1'b1;
                                n_idx       = '0;
                                n_state     = ST_TRAV;
                            end
                        end
                        default: begin
                            n_out = f_rsp('0, STATUS_OK, t_count'(r_count), 1'b1);
                        end
                    endcase
                end
            end
            ST_POP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = f_rsp(t_word'(rd_data), STATUS_OK, t_count'(r_count), 1'b1);
                    n_state     = ST_IDLE;
                end
            end
            ST_TRAV: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = f_rsp(t_word'(rd_data), STATUS_OK, t_count'(r_count), trav_last);
                    if (trav_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = f_wrap(r_front, CNT_W'(n_idx));
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.value_out   = r_out.value_out;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.entry_count = r_out.entry_count;
    assign o_rsp.last_of_run = r_out.last_of_run;

endmodule

@@ hdl/double_ended_queue_unit.sv @@
// Top level of the double-ended queue unit: intake, command queue, execution
//
// channel  dir  modport  payload
// i_req    in   sink     kind[2:0], push_value[31:0] signed
// o_rsp    out  source   value_out[31:0] signed, status[1:0], entry_count[4:0], last_of_run
//
// The two-word command queue registers each request between intake and execution.
// Push and unused kinds set the result register directly; pops read the store, then the result.
// Traverse: one result per cycle after the first store read, while o_rsp is not stalled.
// Synchronous active-low reset empties the queue; the entry store needs no clearing.
// A stalled o_rsp holds the result register and stops execution; intake goes on
// until the command queue fills.
`timescale 1ns / 1ps
`include "double_ended_queue_unit_assert.svh"

module double_ended_queue_unit import deq_pkg::*; #(
    parameter int DEPTH = DEQ_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_req_if.sink    i_req,
    deq_rsp_if.source  o_rsp
);

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;
    logic req_fire;
    logic cmd_push_fire;
    logic rsp_empty;

    deq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_rsp       (o_rsp)
    );

    assign req_fire      = i_req.valid && i_req.ready;
    assign cmd_push_fire = cmd_valid && cmd_ready &&
                           (cmd.op inside {OP_PUSH_BACK, OP_PUSH_FRONT});
    assign rsp_empty     = o_rsp.valid && (o_rsp.status == STATUS_EMPTY);

    `DEQ_ASSERT_NXT(a_intake_queued, i_clk, i_rst_n, req_fire, cmd_valid)
    `DEQ_ASSERT_NXT(a_push_answers, i_clk, i_rst_n, cmd_push_fire, o_rsp.valid)
    `DEQ_ASSERT_IMP(a_empty_count, i_clk, i_rst_n, rsp_empty, o_rsp.entry_count == '0 && o_rsp.value_out == '0)

endmodule

@@ sim/double_ended_queue_unit_tb.sv @@
// Self-checking testbench of the double-ended queue unit with a mirrored deque predictor
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;

    import deq_pkg::*;

    localparam t_kind KIND_SPARE_A = 3'd5;
    localparam t_kind KIND_SPARE_B = 3'd6;
    localparam t_kind KIND_SPARE_C = 3'd7;

    localparam int RANDOM_WORDS  = 430;
    localparam int CALM_TAIL     = 40;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 50;

    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIX
    } t_phase;

    typedef struct {
        t_kind kind;
        t_word value;
        bit    drain_first;
    } t_pending_word;

    logic clk = 1'b0;
    logic rst_n;

    deq_req_if req_bus ();
    deq_rsp_if rsp_bus ();

    double_ended_queue_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #5 clk = ~clk;

    t_pending_word pending_words [$];
    t_rsp          awaited_rsps  [$];

    t_word mirror_store [DEQ_DEPTH];
    int    mirror_front;
    int    mirror_count;

    int error_count;
    int src_gap;
    int sink_gap;

    function automatic t_rsp rsp_of(input t_word value, input t_status status,
                                    input logic last);
        t_rsp r;
        r.value_out   = value;
        r.status      = status;
        r.entry_count = t_count'(mirror_count);
        r.last_of_run = last;
        return r;
    endfunction

    function automatic void predict_request(input t_kind kind, input t_word value);
        int slot;
        t_word popped;
        case (kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (mirror_count >= DEQ_DEPTH) begin
                    awaited_rsps.push_back(rsp_of('0, STATUS_FULL, 1'b1));
                end else begin
                    if (kind == KIND_PUSH_BACK) begin
                        slot = (mirror_front + mirror_count) % DEQ_DEPTH;
                    end else begin
                        mirror_front = (mirror_front + DEQ_DEPTH - 1) % DEQ_DEPTH;
                        slot = mirror_front;
                    end
                    mirror_store[slot] = value;
                    mirror_count++;
                    awaited_rsps.push_back(rsp_of('0, STATUS_OK, 1'b1));
                end
            end
            KIND_POP_BACK, KIND_POP_FRONT: begin
                if (mirror_count == 0) begin
                    awaited_rsps.push_back(rsp_of('0, STATUS_EMPTY, 1'b1));
                end else begin
                    if (kind == KIND_POP_BACK) begin
                        popped = mirror_store[(mirror_front + mirror_count - 1) % DEQ_DEPTH];
                    end else begin
                        popped = mirror_store[mirror_front];
                        mirror_front = (mirror_front + 1) % DEQ_DEPTH;
                    end
                    mirror_count--;
                    awaited_rsps.push_back(rsp_of(popped, STATUS_OK, 1'b1));
                end
            end
            KIND_TRAVERSE: begin
                if (mirror_count == 0) begin
                    awaited_rsps.push_back(rsp_of('0, STATUS_EMPTY, 1'b1));
                end else begin
                    for (int i = 0; i < mirror_count; i++) begin
                        awaited_rsps.push_back(rsp_of(
                            mirror_store[(mirror_front + i) % DEQ_DEPTH], STATUS_OK,
                            i + 1 == mirror_count));
                    end
                end
            end
            default: begin
                awaited_rsps.push_back(rsp_of('0, STATUS_OK, 1'b1));
            end
        endcase
    endfunction

    task automatic report_error(input string field, input logic [31:0] got,
                                input logic [31:0] want);
        if (error_count < REPORT_LIMIT) begin
            $display("ERROR %s: got %0h, want %0h at %0t", field, got, want, $realtime);
        end
        error_count++;
    endtask

    task automatic check_result(input t_word value, input t_status status,
                                input t_count count, input logic last);
        t_rsp want;
        if (awaited_rsps.size() == 0) begin
            report_error("result with nothing awaited", value, '0);
        end else begin
            want = awaited_rsps.pop_front();
            if (value !== want.value_out) report_error("value_out", value, want.value_out);
            if (status !== want.status) begin
                report_error("status", 32'(status), 32'(want.status));
            end
            if (count !== want.entry_count) begin
                report_error("entry_count", 32'(count), 32'(want.entry_count));
            end
            if (last !== want.last_of_run) begin
                report_error("last_of_run", 32'(last), 32'(want.last_of_run));
            end
        end
    endtask

    task automatic add_word(input t_kind kind, input t_word value, input bit drain_first);
        t_pending_word w;
        w.kind        = kind;
        w.value       = value;
        w.drain_first = drain_first;
        pending_words.push_back(w);
    endtask

    function automatic t_word pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_kind pick_kind(input t_phase phase);
        int roll;
        bit push;
        roll = $urandom_range(0, 99);
        if (roll < 3) return t_kind'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
        if (roll < 11) return KIND_TRAVERSE;
        case (phase)
            PHASE_FILL:  push = roll < 90;
            PHASE_DRAIN: push = roll >= 90;
            default:     push = roll < 55;
        endcase
        if (push) return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
    endfunction

    function automatic bit calm_tail();
        return pending_words.size() < CALM_TAIL;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                predict_request(req_bus.kind, req_bus.push_value);
                pending_words.delete(0);
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    req_bus.valid <= 1'b0;
                end else if (pending_words.size() == 0) begin
                    req_bus.valid <= 1'b0;
                end else if (pending_words[0].drain_first && awaited_rsps.size() != 0) begin
                    req_bus.valid <= 1'b0;
                end else if (!calm_tail() && $urandom_range(0, 3) == 0) begin
                    src_gap = $urandom_range(0, 8);
                    req_bus.valid <= 1'b0;
                end else begin
                    req_bus.valid      <= 1'b1;
                    req_bus.kind       <= pending_words[0].kind;
                    req_bus.push_value <= pending_words[0].value;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                check_result(rsp_bus.value_out, rsp_bus.status, rsp_bus.entry_count,
                             rsp_bus.last_of_run);
            end
            if (sink_gap != 0) begin
                sink_gap--;
                rsp_bus.ready <= 1'b0;
            end else if (!calm_tail() && $urandom_range(0, 4) == 0) begin
                sink_gap = $urandom_range(0, 8);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        int useful;
        int span;
        int round;
        t_phase phase;
        t_kind kind;

        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.kind       = KIND_PUSH_BACK;
        req_bus.push_value = '0;
        rsp_bus.ready      = 1'b0;
        mirror_front       = 0;
        mirror_count       = 0;
        error_count        = 0;
        src_gap            = 0;
        sink_gap           = 0;

        // empty cases, first entry at the front, extremes, unused kinds
        add_word(KIND_POP_BACK, '0, 1'b0);
        add_word(KIND_POP_FRONT, '0, 1'b0);
        add_word(KIND_TRAVERSE, '0, 1'b0);
        add_word(KIND_PUSH_FRONT, 32'sh8000_0000, 1'b0);
        add_word(KIND_PUSH_BACK, 32'sh7FFF_FFFF, 1'b0);
        add_word(KIND_PUSH_BACK, -32'sd1, 1'b0);
        add_word(KIND_PUSH_FRONT, '0, 1'b0);
        add_word(KIND_TRAVERSE, '0, 1'b0);
        add_word(KIND_SPARE_A, 32'sh5555_5555, 1'b0);
        add_word(KIND_POP_FRONT, '0, 1'b0);
        add_word(KIND_POP_BACK, '0, 1'b0);
        add_word(KIND_POP_BACK, '0, 1'b0);
        add_word(KIND_POP_FRONT, '0, 1'b0);
        add_word(KIND_POP_FRONT, '0, 1'b0);
        add_word(KIND_PUSH_BACK, 32'sh0F0F_F0F0, 1'b0);
        add_word(KIND_SPARE_B, 32'shAAAA_AAAA, 1'b0);
        add_word(KIND_TRAVERSE, '0, 1'b0);
        add_word(KIND_SPARE_C, '0, 1'b0);
        add_word(KIND_POP_BACK, '0, 1'b0);

        useful = 0;
        round  = 0;
        while (useful < RANDOM_WORDS) begin
            phase = (round < 3) ? t_phase'(round) : t_phase'($urandom_range(0, 2));
            span  = $urandom_range(20, 40);
            for (int i = 0; i < span; i++) begin
                kind = pick_kind(phase);
                add_word(kind, pick_value(), i == 0);
                if (kind <= KIND_TRAVERSE) useful++;
            end
            round++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || awaited_rsps.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_if.sv
hdl/deq_ram.sv
hdl/deq_front.sv
hdl/deq_back.sv
hdl/double_ended_queue_unit.sv
sim/double_ended_queue_unit_tb.sv
